@@ rtl/assert_macros.svh @@
// Assertion macros for the SSTF scheduler RTL.
// The assertions use the clk and rst of the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SSTF_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sstf assertion failed");
`define SSTF_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sstf assertion failed");
`else
`define SSTF_ASSERT(lbl, expr)
`define SSTF_ASSERT_NEXT(lbl, a, b)
`endif

`endif

@@ rtl/sstf_pkg.sv @@
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared constants and types for the SSTF disk request scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sstf_pkg;

  localparam int QUEUE_DEPTH_DEF   = 32;
  localparam int CYLINDER_BITS_DEF = 16;
  localparam int WAIT_BITS_DEF     = 32;
  localparam int SUM_W             = 32;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // mode of one pass over the table
  typedef struct packed {
    logic pick;    // nearest-entry search
    logic inc;     // bump waits
    logic arrive;  // drop entries at target
  } scan_ctrl_t;

  typedef struct packed {
    logic hit;     // entry sits at target
    logic closer;  // entry beats current best
  } scan_stat_t;

endpackage

`default_nettype wire

@@ rtl/sstf_ram.sv @@
// ----------------------------------------------------------------------------
// sstf_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sstf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/sstf_scan_unit.sv @@
// ----------------------------------------------------------------------------
// sstf_scan_unit
// Shared per-entry datapath: seek gap, nearest compare, wait bump, target hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sstf_scan_unit #(
  parameter int CYLINDER_BITS = 16,
  parameter int WAIT_BITS     = 32
) (
  input  wire sstf_pkg::scan_ctrl_t     ctrl,
  input  wire logic [CYLINDER_BITS-1:0] entry_cyl,
  input  wire logic [WAIT_BITS-1:0]     entry_wait,
  input  wire logic [CYLINDER_BITS-1:0] head,
  input  wire logic [CYLINDER_BITS-1:0] target,
  input  wire logic                     best_valid,
  input  wire logic [CYLINDER_BITS-1:0] best_gap,
  output logic      [CYLINDER_BITS-1:0] gap,
  output logic      [WAIT_BITS-1:0]     wait_new,
  output sstf_pkg::scan_stat_t     stat
);
  import sstf_pkg::*;

  always_comb begin
    gap = (entry_cyl > head) ? entry_cyl - head : head - entry_cyl;
    if (ctrl.inc && entry_wait != {WAIT_BITS{1'b1}}) begin
      wait_new = entry_wait + WAIT_BITS'(1);
    end else begin
      wait_new = entry_wait;
    end
    stat.hit    = ctrl.arrive && (entry_cyl == target);
    // strict less keeps the oldest entry on a tie
    stat.closer = ctrl.pick && (!best_valid || gap < best_gap);
  end

endmodule

`default_nettype wire

@@ rtl/sstf_disk_request_scheduler_unit.sv @@
// Throughput: one item at a time, bounded by the single table RAM port sweep
// (one entry per cycle). No result back-pressure.
// Reset (rst, synchronous): table empty, head unknown, no move, total distance zero.
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_unit
// Shortest-seek-first head scheduler with an arrival-ordered request table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sstf_disk_request_scheduler_unit #(
  parameter int QUEUE_DEPTH   = sstf_pkg::QUEUE_DEPTH_DEF,
  parameter int CYLINDER_BITS = sstf_pkg::CYLINDER_BITS_DEF,
  parameter int WAIT_BITS     = sstf_pkg::WAIT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             opcode,
  input  wire logic [CYLINDER_BITS-1:0]         request_cylinder,
  output logic                                  done,
  output logic                                  accepted,
  output logic                                  served,
  output logic [CYLINDER_BITS-1:0]              served_cylinder,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      served_count,
  output logic [sstf_pkg::SUM_W-1:0]            served_wait_sum,
  output logic [CYLINDER_BITS-1:0]              move_distance,
  output logic [CYLINDER_BITS-1:0]              head_position,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      pending_count,
  output logic [sstf_pkg::SUM_W-1:0]            total_distance
);
  import sstf_pkg::*;

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int ENT_W   = CYLINDER_BITS + WAIT_BITS;
  localparam int SUMX_W  = ((WAIT_BITS > SUM_W) ? WAIT_BITS : SUM_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PICK  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  logic [CNT_W-1:0]         count, idx, keep, removed;
  logic                     pv;
  logic [CYLINDER_BITS-1:0] head, target, origin, best_cyl, best_gap;
  logic                     head_known, moving, best_valid;
  logic [SUM_W-1:0]         dist_total, sum;
  scan_ctrl_t               ctrl;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [ENT_W-1:0]         wdata, rdata;
  logic [CYLINDER_BITS-1:0] r_cyl, gap, head_step, move_gap;
  logic [WAIT_BITS-1:0]     r_wait, wait_new;
  scan_stat_t               stat;
  logic                     scan_end;
  logic [SUMX_W-1:0]        sum_ext;
  logic [SUM_W:0]           dist_ext;

  assign r_cyl  = rdata[ENT_W-1:WAIT_BITS];
  assign r_wait = rdata[WAIT_BITS-1:0];
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign head_position  = head;
  assign pending_count  = count;
  assign total_distance = dist_total;

  sstf_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  sstf_scan_unit #(.CYLINDER_BITS(CYLINDER_BITS), .WAIT_BITS(WAIT_BITS)) u_scan (
    .ctrl       (ctrl),
    .entry_cyl  (r_cyl),
    .entry_wait (r_wait),
    .head       (head),
    .target     (target),
    .best_valid (best_valid),
    .best_gap   (best_gap),
    .gap        (gap),
    .wait_new   (wait_new),
    .stat       (stat)
  );

  always_comb begin
    scan_end = (idx == count) && !pv;
    sum_ext  = SUMX_W'(sum) + SUMX_W'(wait_new);
    move_gap = (target > origin) ? target - origin : origin - target;
    dist_ext = {1'b0, dist_total} + (SUM_W + 1)'(move_gap);
    if (target > head) begin
      head_step = head + CYLINDER_BITS'(1);
    end else if (target < head) begin
      head_step = head - CYLINDER_BITS'(1);
    end else begin
      head_step = head;
    end
    we    = 1'b0;
    waddr = keep[IDX_W-1:0];
    wdata = {r_cyl, wait_new};
    if (state == S_IDLE) begin
      we    = start && opcode == OP_ADD && head_known && count != CNT_W'(QUEUE_DEPTH);
      waddr = count[IDX_W-1:0];
      wdata = {request_cylinder, {WAIT_BITS{1'b0}}};
    end else if (state == S_SWEEP) begin
      we = pv && !stat.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head       <= '0;
      head_known <= 1'b0;
      target     <= '0;
      moving     <= 1'b0;
      origin     <= '0;
      dist_total <= '0;
      pv         <= 1'b0;
      idx        <= '0;
      ctrl       <= '0;
    end else begin
      // read issue, one entry per beat
      if (state == S_PICK || state == S_SWEEP) begin
        if (idx != count) begin
          idx  <= idx + CNT_W'(1);
          pv   <= 1'b1;
        end else begin
          pv <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            accepted        <= 1'b1;
            served          <= 1'b0;
            served_cylinder <= '0;
            removed         <= '0;
            sum             <= '0;
            move_distance   <= '0;
            idx             <= '0;
            pv              <= 1'b0;
            keep            <= '0;
            best_valid      <= 1'b0;
            state           <= S_DONE;
            if (opcode == OP_ADD) begin
              if (!head_known) begin
                head       <= request_cylinder;
                head_known <= 1'b1;
              end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                accepted <= 1'b0;
              end else begin
                count <= count + CNT_W'(1);
                if (moving) begin
                  if (target > origin) begin
                    if (request_cylinder > head && request_cylinder < target)
                      target <= request_cylinder;
                  end else begin
                    if (request_cylinder < head && request_cylinder > target)
                      target <= request_cylinder;
                  end
                end
              end
            end else if (!moving) begin
              if (count != '0) begin
                ctrl  <= '{pick: 1'b1, inc: 1'b0, arrive: 1'b0};
                state <= S_PICK;
              end
            end else begin
              head  <= head_step;
              ctrl  <= '{pick: 1'b0, inc: 1'b1, arrive: head_step == target};
              state <= S_SWEEP;
            end
          end
        end
        S_PICK: begin
          if (pv && stat.closer) begin
            best_valid <= 1'b1;
            best_cyl   <= r_cyl;
            best_gap   <= gap;
          end
          if (scan_end) begin
            target <= best_cyl;
            origin <= head;
            moving <= 1'b1;
            if (best_gap == '0) begin
              // nearest request is under the head: serve it now
              idx   <= '0;
              ctrl  <= '{pick: 1'b0, inc: 1'b0, arrive: 1'b1};
              state <= S_SWEEP;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SWEEP: begin
          if (pv) begin
            if (stat.hit) begin
              removed <= removed + CNT_W'(1);
              sum     <= (sum_ext > SUMX_W'({SUM_W{1'b1}})) ? {SUM_W{1'b1}}
                                                            : sum_ext[SUM_W-1:0];
            end else begin
              keep <= keep + CNT_W'(1);
            end
          end
          if (scan_end) begin
            count <= keep;
            if (ctrl.arrive) begin
              moving          <= 1'b0;
              served          <= 1'b1;
              served_cylinder <= target;
              move_distance   <= move_gap;
              dist_total      <= dist_ext[SUM_W] ? {SUM_W{1'b1}} : dist_ext[SUM_W-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign served_count    = removed;
  assign served_wait_sum = sum;

  `SSTF_ASSERT(a_count_max, count <= CNT_W'(QUEUE_DEPTH))
  `SSTF_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `SSTF_ASSERT_NEXT(a_done_idle, done, !busy)
  `SSTF_ASSERT(a_keep_behind, state != S_SWEEP || keep <= idx)
  `SSTF_ASSERT(a_moving_pending, !moving || count != '0 || state == S_SWEEP)

endmodule

`default_nettype wire
